// ===== rtl/wast_pkg.sv =====
// Package with shared types and constants of the weekly alarm slot table.
`timescale 1ns / 1ps
package wast_pkg;

    typedef enum logic [3:0] {
        ACT_ADD    = 4'd0,
        ACT_TIME   = 4'd1,
        ACT_REPEAT = 4'd2,
        ACT_ENABLE = 4'd3,
        ACT_ALL    = 4'd4,
        ACT_DELETE = 4'd5,
        ACT_CLEAR  = 4'd6,
        ACT_READ   = 4'd7,
        ACT_TICK   = 4'd8
    } action_t;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    localparam int CMD_W = 30;
    localparam int RES_W = 35;

    typedef struct packed {
        logic [2:0] weekday;
        logic [6:0] repeat_days;
        logic       alarm_on;
        logic [5:0] min_val;
        logic [4:0] hr_val;
        logic [3:0] key_id;
        logic [3:0] action;
    } cmd_t;

    typedef struct packed {
        logic [4:0]  entry_count;
        logic [22:0] info_word;
        logic [3:0]  fired_slot;
        logic        fired;
        logic [1:0]  status;
    } res_t;

    typedef struct packed {
        logic [6:0] rpt;
        logic       en;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [3:0] id;
    } entry_t;

endpackage

// ===== rtl/wast_cmd_fifo.sv =====
// Two-entry command queue between the accepting front end and the table engine.
`timescale 1ns / 1ps
module wast_cmd_fifo
    import wast_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);
    cmd_t       mem_reg [2];
    logic       wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ pop;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_cmd;
        end
    end
endmodule

// ===== rtl/wast_engine.sv =====
// Table engine: stores entries; for modify, delete and tick commands it walks slots one per cycle.
`timescale 1ns / 1ps
module wast_engine
    import wast_pkg::*;
#(
    parameter int MAX_ALARMS = 8
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic armed,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);
    localparam int IW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CW = $clog2(MAX_ALARMS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_SHFT = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t         state_reg;
    entry_t         tab_reg [MAX_ALARMS];
    logic [CW-1:0]  cnt_reg;
    logic [3:0]     last_reg;
    logic [CW-1:0]  idx_reg;
    cmd_t           cmd_reg;
    logic [1:0]     status_reg;
    logic           fired_reg;
    logic [22:0]    info_reg;
    logic [CW-1:0]  cnt_ext;
    entry_t         cur, nxt;
    logic [4:0]     cnt5;
    logic           hit_time, day_ok;
    action_t        act;

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign act       = action_t'(cmd_reg.action);
    assign cur       = tab_reg[idx_reg[IW-1:0]];
    assign nxt       = (idx_reg + 1'b1 < cnt_reg) ? tab_reg[IW'(idx_reg + 1'b1)] : '0;
    assign cnt5      = 5'(cnt_reg);
    assign cnt_ext   = CW'(MAX_ALARMS);
    assign hit_time  = (cur.hour == cmd_reg.hr_val) && (cur.minute == cmd_reg.min_val)
                       && cur.en;
    assign day_ok    = (cur.rpt == 7'd0) ||
                       ((cur.rpt & (7'd1 << cmd_reg.weekday)) != 7'd0);

    assign res = '{entry_count: cnt5, info_word: info_reg, fired_slot: last_reg,
                   fired: fired_reg, status: status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            last_reg   <= '0;
            idx_reg    <= '0;
            cmd_reg    <= '0;
            status_reg <= ST_DONE;
            fired_reg  <= 1'b0;
            info_reg   <= '0;
            for (int k = 0; k < MAX_ALARMS; k++) tab_reg[k] <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg    <= cmd;
                        idx_reg    <= '0;
                        status_reg <= ST_DONE;
                        fired_reg  <= 1'b0;
                        info_reg   <= '0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    unique case (act)
                        ACT_ADD: begin
                            if (cnt_reg >= cnt_ext) begin
                                status_reg <= ST_FULL;
                            end else begin
                                tab_reg[IW'(cnt_reg)] <= '{rpt: cmd_reg.repeat_days,
                                    en: cmd_reg.alarm_on, minute: cmd_reg.min_val,
                                    hour: cmd_reg.hr_val, id: cmd_reg.key_id};
                                cnt_reg <= cnt_reg + 1'b1;
                            end
                            state_reg <= S_OUT;
                        end
                        ACT_TIME, ACT_REPEAT, ACT_ENABLE, ACT_ALL, ACT_DELETE: begin
                            if (idx_reg >= cnt_reg) begin
                                status_reg <= ST_MISSING;
                                state_reg  <= S_OUT;
                            end else if (cur.id != cmd_reg.key_id) begin
                                idx_reg <= idx_reg + 1'b1;
                            end else if (act == ACT_DELETE) begin
                                state_reg <= S_SHFT;
                            end else begin
                                if (act == ACT_TIME || act == ACT_ALL) begin
                                    tab_reg[idx_reg[IW-1:0]].hour   <= cmd_reg.hr_val;
                                    tab_reg[idx_reg[IW-1:0]].minute <= cmd_reg.min_val;
                                end
                                if (act == ACT_ENABLE || act == ACT_ALL)
                                    tab_reg[idx_reg[IW-1:0]].en <= cmd_reg.alarm_on;
                                if (act == ACT_REPEAT || act == ACT_ALL)
                                    tab_reg[idx_reg[IW-1:0]].rpt <= cmd_reg.repeat_days;
                                state_reg <= S_OUT;
                            end
                        end
                        ACT_CLEAR: begin
                            for (int k = 0; k < MAX_ALARMS; k++) tab_reg[k] <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_OUT;
                        end
                        ACT_READ: begin
                            if ({1'b0, cmd_reg.key_id} >= 5'(cnt_reg))
                                status_reg <= ST_MISSING;
                            else
                                info_reg <= tab_reg[IW'(cmd_reg.key_id)];
                            state_reg <= S_OUT;
                        end
                        ACT_TICK: begin
                            if (armed && idx_reg < cnt_reg) begin
                                if (hit_time && day_ok) begin
                                    if (cur.rpt == 7'd0) tab_reg[idx_reg[IW-1:0]].en <= 1'b0;
                                    last_reg  <= 4'(idx_reg);
                                    fired_reg <= 1'b1;
                                    state_reg <= S_OUT;
                                end else begin
                                    idx_reg <= idx_reg + 1'b1;
                                end
                            end else begin
                                state_reg <= S_OUT;
                            end
                        end
                        default: state_reg <= S_OUT;
                    endcase
                end
                S_SHFT: begin
                    if (idx_reg + 1'b1 < cnt_reg) begin
                        tab_reg[idx_reg[IW-1:0]] <= '{rpt: nxt.rpt, en: nxt.en,
                            minute: nxt.minute, hour: nxt.hour, id: cur.id};
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        tab_reg[idx_reg[IW-1:0]] <= '0;
                        cnt_reg   <= cnt_reg - 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (res_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/weekly_alarm_slot_table.sv =====
// Top level of the weekly alarm slot table.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one command transaction: tuser = action; tdata = key_id,
//   hr_val, min_val, alarm_on, repeat_days, weekday from bit 0 up.
//   m_axis returns one result transaction per command: status, fired, fired_slot,
//   info_word, entry_count from bit 0 up.
//   cfg_we/cfg_wdata write alarms_armed (reset 1); write only while idle.
// Flow:
//   A command passes a two-entry queue, then the engine walks the table one
//   slot per cycle for modify, tick and delete; add, clear, read and unknown
//   actions need no walk. One command is executed at a time; the engine takes
//   the next one only after the result has been accepted on m_axis.
// Reset:
//   aresetn low empties the table and queue, count and last fired slot go to 0.
// Stall:
//   While m_axis_tready is low the result holds; the queue still takes up
//   to two commands before s_axis_tready drops.
module weekly_alarm_slot_table
    import wast_pkg::*;
#(
    parameter int MAX_ALARMS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // key_id, hr_val, min_val, alarm_on, repeat_days, weekday
    input  logic [31:0] s_axis_tdata,
    // action
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, fired, fired_slot, info_word, entry_count
    output logic [39:0] m_axis_tdata
);
    logic armed_reg;
    logic q_valid, q_ready;
    cmd_t q_cmd;
    res_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b1;
        end else if (cfg_we) begin
            armed_reg <= cfg_wdata;
        end
    end

    wast_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (cmd_t'({s_axis_tdata[CMD_W-5:0], s_axis_tuser})),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    wast_engine #(.MAX_ALARMS(MAX_ALARMS)) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .armed     (armed_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {5'd0, res};

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3)) else $error("bad status");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[34:30] <= 5'(MAX_ALARMS))) else $error("count");
    a_fire_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[29:7] == 23'd0))
        else $error("fired with info");
endmodule

// ===== verif/tb_weekly_alarm_slot_table.sv =====
// Testbench of the weekly alarm slot table: directed and random commands checked against a local table model.
`timescale 1ns / 1ps
module tb_weekly_alarm_slot_table;
    import wast_pkg::*;

    localparam int SLOTS = 8;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;

    weekly_alarm_slot_table #(.MAX_ALARMS(SLOTS)) dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    cmd_t   cmd_queue[$];
    res_t   expected_results[$];
    entry_t table_copy[SLOTS];
    int     table_count;
    logic [3:0] last_slot;
    logic   armed;
    int     errors;
    int     sent;
    int     received;
    int     hold_cycles;
    int     gap;
    bit     drain_mode;

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int find_alarm(logic [3:0] id);
        for (int i = 0; i < table_count; i++)
            if (table_copy[i].id == id) return i;
        return -1;
    endfunction

    // Apply one command to the local table and return its result.
    function automatic res_t apply_command(cmd_t c);
        res_t   r;
        int     k;
        logic [3:0] keep;
        r = '0;
        case (c.action)
            ACT_ADD: begin
                if (table_count >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    table_copy[table_count] = '{rpt: c.repeat_days, en: c.alarm_on,
                        minute: c.min_val, hour: c.hr_val, id: c.key_id};
                    table_count++;
                end
            end
            ACT_TIME, ACT_REPEAT, ACT_ENABLE, ACT_ALL: begin
                k = find_alarm(c.key_id);
                if (k < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    if (c.action == ACT_TIME || c.action == ACT_ALL) begin
                        table_copy[k].hour = c.hr_val;
                        table_copy[k].minute = c.min_val;
                    end
                    if (c.action == ACT_ENABLE || c.action == ACT_ALL)
                        table_copy[k].en = c.alarm_on;
                    if (c.action == ACT_REPEAT || c.action == ACT_ALL)
                        table_copy[k].rpt = c.repeat_days;
                end
            end
            ACT_DELETE: begin
                k = find_alarm(c.key_id);
                if (k < 0) begin
                    r.status = ST_MISSING;
                end else begin
                    for (int j = k; j + 1 < table_count; j++) begin
                        keep = table_copy[j].id;
                        table_copy[j] = table_copy[j + 1];
                        table_copy[j].id = keep;
                    end
                    table_copy[table_count - 1] = '0;
                    table_count--;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) table_copy[i] = '0;
                table_count = 0;
            end
            ACT_READ: begin
                if (c.key_id >= table_count) r.status = ST_MISSING;
                else r.info_word = table_copy[c.key_id];
            end
            ACT_TICK: begin
                if (armed) begin
                    for (int i = 0; i < table_count; i++) begin
                        if (table_copy[i].hour == c.hr_val &&
                            table_copy[i].minute == c.min_val && table_copy[i].en &&
                            (table_copy[i].rpt == 0 || table_copy[i].rpt[c.weekday % 8 > 6 ?
                                0 : c.weekday] && c.weekday != 7)) begin
                            if (table_copy[i].rpt == 0) table_copy[i].en = 1'b0;
                            last_slot = i[3:0];
                            r.fired = 1'b1;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.fired_slot = last_slot;
        r.entry_count = table_count[4:0];
        return r;
    endfunction

    function automatic cmd_t make_cmd(int act, int id, int hr, int mn, int on, int rp, int wd);
        cmd_t c;
        c.action = act[3:0];
        c.key_id = id[3:0];
        c.hr_val = hr[4:0];
        c.min_val = mn[5:0];
        c.alarm_on = on[0];
        c.repeat_days = rp[6:0];
        c.weekday = wd[2:0];
        return c;
    endfunction

    // Weighted mix with some unknown actions: ids and times mostly from a small pool so modify and tick hit often.
    function automatic cmd_t random_cmd();
        int act;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) act = ACT_ADD;
        else if (pick < 45) act = $urandom_range(ACT_TIME, ACT_ALL);
        else if (pick < 55) act = ACT_DELETE;
        else if (pick < 58) act = ACT_CLEAR;
        else if (pick < 68) act = ACT_READ;
        else if (pick < 95) act = ACT_TICK;
        else act = $urandom_range(0, 15);
        if ($urandom_range(0, 9) < 8)
            return make_cmd(act, $urandom_range(0, 3), $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom_range(0, 1),
                ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 127),
                $urandom_range(0, 7));
        return make_cmd(act, $urandom_range(0, 15), $urandom_range(0, 31),
            $urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 127),
            $urandom_range(0, 7));
    endfunction

    // Feed commands in order; the model is updated when each transaction is accepted.
    always @(posedge aclk) begin
        cmd_t next_cmd;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(
                    apply_command(cmd_t'({s_axis_tdata[25:0], s_axis_tuser})));
                sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap > 0 || cmd_queue.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                    if (gap > 0) gap <= gap - 1;
                end else begin
                    next_cmd = cmd_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'd0, next_cmd[29:4]};
                    s_axis_tuser <= next_cmd.action;
                    if (!drain_mode && $urandom_range(0, 2) == 0)
                        gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = res_t'(m_axis_tdata[34:0]);
                received++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transaction %h", m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status exp %0d got %0d", want.status, got.status); errors++;
                    end
                    if (got.fired !== want.fired) begin
                        $error("fired exp %0d got %0d", want.fired, got.fired); errors++;
                    end
                    if (got.fired_slot !== want.fired_slot) begin
                        $error("fired_slot exp %0d got %0d", want.fired_slot,
                            got.fired_slot); errors++;
                    end
                    if (got.info_word !== want.info_word) begin
                        $error("info_word exp %h got %h", want.info_word,
                            got.info_word); errors++;
                    end
                    if (got.entry_count !== want.entry_count) begin
                        $error("entry_count exp %0d got %0d", want.entry_count,
                            got.entry_count); errors++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end else if (!drain_mode && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                if ($urandom_range(0, 15) == 0) hold_cycles <= $urandom_range(10, 40);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        while (cmd_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (2 * SLOTS + 10) @(posedge aclk);
    endtask

    task automatic set_armed(logic v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        armed = v;
    endtask

    initial begin
        errors = 0; sent = 0; received = 0; hold_cycles = 0; drain_mode = 0;
        table_count = 0; last_slot = 0; armed = 1'b1;
        for (int i = 0; i < SLOTS; i++) table_copy[i] = '0;
        aresetn = 0; cfg_we = 0; cfg_wdata = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = '0; m_axis_tready = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: fill past full, duplicates, modify, delete shift, reads, ticks, unknown action, clear.
        for (int i = 0; i < 9; i++)
            cmd_queue.push_back(make_cmd(ACT_ADD, (i == 8) ? 15 : i % 7, i == 0 ? 31 : i,
                i == 0 ? 63 : 0, 1, i == 0 ? 127 : (i == 1 ? 0 : 1 << (i % 7)), 0));
        cmd_queue.push_back(make_cmd(ACT_TICK, 0, 1, 0, 0, 0, 7));
        cmd_queue.push_back(make_cmd(ACT_TICK, 0, 1, 0, 0, 0, 3));
        cmd_queue.push_back(make_cmd(ACT_TICK, 0, 31, 63, 0, 0, 6));
        cmd_queue.push_back(make_cmd(ACT_TICK, 0, 31, 63, 0, 0, 7));
        cmd_queue.push_back(make_cmd(ACT_TIME, 0, 2, 5, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_REPEAT, 3, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_ENABLE, 2, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_ALL, 4, 17, 42, 1, 85, 0));
        cmd_queue.push_back(make_cmd(ACT_ALL, 12, 17, 42, 1, 85, 0));
        cmd_queue.push_back(make_cmd(ACT_DELETE, 1, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_DELETE, 9, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_READ, 6, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_READ, 7, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_READ, 15, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(15, 15, 31, 63, 1, 127, 7));
        cmd_queue.push_back(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0));
        wait_idle();

        // Long receiver hold while the sender keeps offering.
        @(negedge aclk);
        hold_cycles = 120;
        for (int i = 0; i < 12; i++) cmd_queue.push_back(random_cmd());
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            set_armed(phase % 2 == 0 ? 1'b0 : 1'b1);
            for (int i = 0; i < 200; i++) cmd_queue.push_back(random_cmd());
            drain_mode = (phase == 2);
            wait_idle();
            drain_mode = 0;
        end
        set_armed(1'b1);
        for (int i = 0; i < 20; i++) cmd_queue.push_back(random_cmd());
        wait_idle();

        $display("Sent %0d commands, checked %0d results, armed flag toggled both ways.",
            sent, received);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
